### rtl/i2f_pkg.sv
`timescale 1ns / 1ps

package i2f_pkg;

	// Operand and result widths
	localparam int unsigned INT_W  = 32;
	localparam int unsigned FLT_W  = 32;
	localparam int unsigned EXP_W  = 8;
	localparam int unsigned FRAC_W = 23;

	// Width of a leading-zero count over one operand
	localparam int unsigned LZ_W = $clog2(INT_W);

	// Biased exponent of a magnitude whose leading one sits at the top bit:
	// bit length INT_W plus the offset 126
	localparam logic [EXP_W-1:0] EXP_TOP = EXP_W'(126 + INT_W);

	// Rounding bits below the fraction after normalization
	localparam int unsigned GUARD_POS = INT_W - 2 - FRAC_W;

endpackage

### rtl/i2f_lzc.sv
`timescale 1ns / 1ps

module i2f_lzc
	import i2f_pkg::*;
(
	input  logic [INT_W-1:0] value,
	output logic [LZ_W-1:0]  count
);

	// Priority encode from the bottom up so the highest set bit wins
	always_comb begin
		count = LZ_W'(INT_W - 1);
		for (int i = 0; i < INT_W; i++) begin
			if (value[i]) begin
				count = LZ_W'(INT_W - 1 - i);
			end
		end
	end

endmodule

### rtl/int32_to_float32.sv
`timescale 1ns / 1ps
// Converts a signed 32-bit integer to an IEEE 754 single-precision bit pattern.
// Output: done and float_bits are driven straight from the stage 4 registers.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Stages: sign/magnitude, leading-zero count, normalize shift, round and pack.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.

module int32_to_float32
	import i2f_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [INT_W-1:0] int_value,
	output logic                    done,
	output logic [FLT_W-1:0]        float_bits
);

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic             sign_s1, sign_s2, sign_s3;
	logic [INT_W-1:0] mag_s1, mag_s2;
	logic [LZ_W-1:0]  lz_s2;
	logic             zero_s2, zero_s3;
	logic [LZ_W-1:0]  lz_c;
	logic [INT_W-1:0] norm_s3;
	logic [EXP_W-1:0] exp_s3;
	logic             guard_c, sticky_c, lsb_c, round_up_c;
	logic [EXP_W+FRAC_W-1:0] body_c;
	logic [FLT_W-1:0] float_s4;

	// Never hold off a transaction
	assign busy = 1'b0;

	// Advance valid bits every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: split into sign and magnitude; the most negative value wraps to 2^31
	always_ff @(posedge clk) begin
		sign_s1 <= int_value[INT_W-1];
		mag_s1  <= int_value[INT_W-1] ? (INT_W'(0) - INT_W'(int_value))
		                              : INT_W'(int_value);
	end

	// Stage 2: count leading zeros of the magnitude
	i2f_lzc u_lzc (
		.value (mag_s1),
		.count (lz_c)
	);

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		mag_s2  <= mag_s1;
		lz_s2   <= lz_c;
		zero_s2 <= (mag_s1 == '0);
	end

	// Stage 3: move the leading one to the top bit and form the exponent
	always_ff @(posedge clk) begin
		sign_s3 <= sign_s2;
		zero_s3 <= zero_s2;
		norm_s3 <= mag_s2 << lz_s2;
		exp_s3  <= EXP_TOP - EXP_W'(lz_s2);
	end

	// Stage 4: round to nearest even; a fraction carry ripples into the exponent
	assign guard_c    = norm_s3[GUARD_POS];
	assign sticky_c   = |norm_s3[GUARD_POS-1:0];
	assign lsb_c      = norm_s3[GUARD_POS+1];
	assign round_up_c = guard_c && (sticky_c || lsb_c);
	assign body_c     = {exp_s3, norm_s3[INT_W-2 -: FRAC_W]}
	                    + (EXP_W+FRAC_W)'(round_up_c);

	always_ff @(posedge clk) begin
		float_s4 <= zero_s3 ? '0 : {sign_s3, body_c};
	end

	assign done       = valid_s4;
	assign float_bits = float_s4;

	// Stage 1 valid advances one stage per cycle
	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("stage 1 valid did not advance");

	// A nonzero magnitude is normalized with its leading one at the top
	a_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !zero_s3) |-> norm_s3[INT_W-1])
		else $error("normalized magnitude lacks leading one");

	// No negative zero is produced
	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && float_bits[FLT_W-2:0] == '0) |-> !float_bits[FLT_W-1])
		else $error("negative zero produced");

	// A nonzero result has an exponent between 2^0 and 2^31
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && float_bits[FLT_W-2:0] != '0) |->
		(float_bits[FLT_W-2 -: EXP_W] >= EXP_W'(127) &&
		 float_bits[FLT_W-2 -: EXP_W] <= EXP_TOP))
		else $error("exponent out of range");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import i2f_pkg::*;

	typedef struct {
		logic signed [INT_W-1:0] operand;
		logic [FLT_W-1:0]        bits;
	} conversion_t;

	localparam int unsigned RANDOM_COUNT = 1250;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic signed [INT_W-1:0] int_value = '0;
	logic                    busy;
	logic                    done;
	logic [FLT_W-1:0]        float_bits;

	logic signed [INT_W-1:0] operand_queue[$];
	conversion_t             pending_floats[$];
	int unsigned             total_operands = 0;
	int unsigned             issued = 0;
	int unsigned             accepted = 0;
	int unsigned             checked = 0;
	int unsigned             rounded_up = 0;
	int unsigned             exp_carries = 0;
	int unsigned             negatives = 0;
	int unsigned             errors = 0;
	int unsigned             stall_cycles = 0;

	int32_to_float32 u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.int_value  (int_value),
		.done       (done),
		.float_bits (float_bits)
	);

	always #10 clk = ~clk;

	// Normalize the magnitude to the top bit, then round the dropped bits to nearest even
	function automatic logic [FLT_W-1:0] single_of(input logic signed [INT_W-1:0] v,
			output bit did_round, output bit did_carry);
		logic [INT_W-1:0]  mag;
		logic [INT_W-1:0]  norm;
		logic [EXP_W-1:0]  biased;
		logic [FRAC_W-1:0] frac;
		logic              carry;
		int unsigned       lz;
		bit                found;
		did_round = 1'b0;
		did_carry = 1'b0;
		mag = v[INT_W-1] ? (~v + 1'b1) : v;
		if (mag == '0) begin
			return '0;
		end
		lz = 0;
		found = 1'b0;
		for (int i = INT_W - 1; i >= 0; i--) begin
			if (!found && mag[i]) begin
				found = 1'b1;
				lz = INT_W - 1 - i;
			end
		end
		norm = mag << lz;
		biased = EXP_TOP - EXP_W'(lz);
		frac = norm[INT_W-2 -: FRAC_W];
		if (norm[GUARD_POS] && ((|norm[GUARD_POS-1:0]) || frac[0])) begin
			did_round = 1'b1;
			{carry, frac} = {1'b0, frac} + 1'b1;
			if (carry) begin
				did_carry = 1'b1;
				biased = biased + 1'b1;
			end
		end
		return {v[INT_W-1], biased, frac};
	endfunction

	// Drive operands; record the expected float for each accepted transaction
	always @(posedge clk) begin
		conversion_t entry;
		bit          r, c;
		bit          hold_off;
		if (arst_n) begin
			if (start && !busy) begin
				entry.operand = int_value;
				entry.bits = single_of(int_value, r, c);
				pending_floats.push_back(entry);
				accepted <= accepted + 1;
				rounded_up <= rounded_up + r;
				exp_carries <= exp_carries + c;
				negatives <= negatives + int_value[INT_W-1];
			end
			if (!start || !busy) begin
				hold_off = !(issued >= 500 && issued < 800) && ($urandom_range(0, 99) < 27);
				if (operand_queue.size() != 0 && !hold_off) begin
					start <= 1'b1;
					int_value <= operand_queue.pop_front();
					issued <= issued + 1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Compare each result with the oldest outstanding conversion
	always @(posedge clk) begin
		conversion_t entry;
		if (arst_n && done) begin
			if (pending_floats.size() == 0) begin
				$display("%0t: float_bits %h with no transaction outstanding", $time, float_bits);
				errors <= errors + 1;
			end else begin
				entry = pending_floats.pop_front();
				checked <= checked + 1;
				if (float_bits !== entry.bits) begin
					$display("%0t: int_value %h: expected float_bits %h, actual %h",
						$time, entry.operand, entry.bits, float_bits);
					errors <= errors + 1;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("testbench: errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		logic [INT_W-1:0] mag;
		logic [INT_W-1:0] mask;
		int unsigned      kind;
		int unsigned      len;
		int unsigned      sh;

		// Directed: zero, extremes, exact widths, ties to even and rounding carries
		operand_queue.push_back(32'sh0000_0000);
		operand_queue.push_back(32'sh0000_0001);
		operand_queue.push_back(32'shFFFF_FFFF);
		operand_queue.push_back(32'sh7FFF_FFFF);
		operand_queue.push_back(32'sh8000_0000);
		operand_queue.push_back(32'sh8000_0001);
		operand_queue.push_back(32'sh00FF_FFFF);
		operand_queue.push_back(32'shFF00_0001);
		operand_queue.push_back(32'sh0100_0000);
		operand_queue.push_back(32'sh0100_0001);
		operand_queue.push_back(32'sh0100_0003);
		operand_queue.push_back(32'shFEFF_FFFD);
		operand_queue.push_back(32'sh01FF_FFFF);
		operand_queue.push_back(32'sh0200_0002);
		operand_queue.push_back(32'sh0200_0006);
		operand_queue.push_back(32'sh7FFF_FF80);
		operand_queue.push_back(32'sh7FFF_FF40);
		operand_queue.push_back(32'sh7FFF_FFC0);
		operand_queue.push_back(32'sh4000_0040);
		operand_queue.push_back(32'sh5555_5555);
		operand_queue.push_back(32'shAAAA_AAAA);
		operand_queue.push_back(32'shFFFF_FFFE);
		operand_queue.push_back(32'sh0000_0400);

		// Random: full range, chosen widths, exact ties and near-carry mantissas
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				operand_queue.push_back($urandom());
			end else begin
				len = (kind < 7) ? $urandom_range(1, 31) : $urandom_range(25, 31);
				mask = (32'h1 << len) - 1;
				mag = ($urandom() & mask) | (32'h1 << (len - 1));
				sh = (len > 24) ? len - 24 : 0;
				if (kind == 7 || kind == 8) begin
					mag = (mag & ~((32'h1 << (sh - 1)) - 1)) | (32'h1 << (sh - 1));
				end else if (kind == 9) begin
					mag = (mask & ~((32'h1 << sh) - 1)) | ($urandom() & ((32'h1 << sh) - 1))
						| (32'h1 << (sh - 1));
				end
				operand_queue.push_back($urandom_range(0, 1) ? -mag : mag);
			end
		end
		total_operands = operand_queue.size();

		// Hold reset, then release
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for every conversion to come back
		wait (accepted == total_operands);
		while (pending_floats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d conversions checked, %0d negative, %0d rounded up, %0d carried into the exponent",
			checked, negatives, rounded_up, exp_carries);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("summary: %0d mismatches", errors);
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
